/* sv/sfc_pkg.sv */
// Shared constants and types for the streaming FIR convolver.
package sfc_pkg;

  localparam int MAX_TAPS  = 64;
  localparam int MAX_FRAME = 4096;

  localparam int DATA_W   = 16;                         // Q1.15 sample / coefficient
  localparam int IDX_W    = 6;                          // coef_index field
  localparam int PROD_W   = 2 * DATA_W;                 // Q2.30 product
  localparam int ACC_W    = PROD_W + $clog2(MAX_TAPS);  // exact sum of all taps
  localparam int TCNT_W   = $clog2(MAX_TAPS) + 1;       // holds 0..MAX_TAPS
  localparam int SEEN_W   = $clog2(MAX_TAPS);           // holds 0..MAX_TAPS/2
  localparam int FPOS_W   = $clog2(MAX_FRAME);          // holds 0..MAX_FRAME-1
  localparam int FLEN_W   = FPOS_W + 1;                 // holds 1..MAX_FRAME

  localparam int CFG_TAPS_W  = 7;
  localparam int CFG_FRAME_W = 13;
  localparam int CFG_DATA_W  = 13;
  localparam int CFG_ADDR_W  = 1;

  localparam int IN_TDATA_W  = 24;  // coef_index, value, zero fill
  localparam int OUT_TDATA_W = 16;  // out_sample

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_TAP_COUNT = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_FRAME_LEN = 1'd1;

  // input item kinds
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_COEF   = 1'b1;

  // partial sum traveling down the cell row
  typedef struct packed {
    logic                    vld;
    logic signed [ACC_W-1:0] sum;
  } sfc_wave_t;

  // finished sum handed to the output stage
  typedef struct packed {
    logic                    vld;
    logic signed [ACC_W-1:0] sum;
    logic                    last;
  } sfc_done_t;

endpackage

/* sv/sfc_cell.sv */
// One tap cell: holds a coefficient and a history sample, adds its product to the passing sum.
module sfc_cell (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 shift_en,
  input  logic signed [sfc_pkg::DATA_W-1:0]    x_in,
  output logic signed [sfc_pkg::DATA_W-1:0]    x_out,
  input  logic                                 coef_we,
  input  logic signed [sfc_pkg::DATA_W-1:0]    coef_in,
  input  logic                                 tap_en,
  input  sfc_pkg::sfc_wave_t                   wave_in,
  output sfc_pkg::sfc_wave_t                   wave_out
);
  import sfc_pkg::*;

  logic signed [DATA_W-1:0] x_r, x_nxt;
  logic signed [DATA_W-1:0] coef_r, coef_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic                     vld_r, vld_nxt;
  logic signed [ACC_W-1:0]  sum_r, sum_nxt;

  always_comb begin
    x_nxt    = shift_en ? x_in : x_r;
    coef_nxt = coef_we ? coef_in : coef_r;
    // taps beyond tap_count contribute nothing
    prod_nxt = tap_en ? PROD_W'(coef_r * x_r) : '0;
    vld_nxt  = wave_in.vld;
    sum_nxt  = wave_in.sum + ACC_W'(prod_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r    <= '0;
      coef_r <= '0;
      vld_r  <= 1'b0;
    end else begin
      x_r    <= x_nxt;
      coef_r <= coef_nxt;
      vld_r  <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    sum_r  <= sum_nxt;
  end

  assign x_out        = x_r;
  assign wave_out.vld = vld_r;
  assign wave_out.sum = sum_r;

endmodule

/* sv/sfc_out_stage.sv */
// Output stage: round and saturate to Q1.15, output register plus one holding slot.
module sfc_out_stage (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  sfc_pkg::sfc_done_t                    done,
  output logic                                  pend_full,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [sfc_pkg::OUT_TDATA_W-1:0]       out_tdata,
  output logic                                  out_tlast
);
  import sfc_pkg::*;

  localparam int RND_W = ACC_W + 1;
  localparam int Q_W   = RND_W - (DATA_W - 1);
  localparam logic signed [Q_W-1:0] Q_MAX = Q_W'((1 << (DATA_W - 1)) - 1);
  localparam logic signed [Q_W-1:0] Q_MIN = -Q_W'(1 << (DATA_W - 1));

  logic signed [RND_W-1:0]  rnd;
  logic signed [Q_W-1:0]    q;
  logic signed [DATA_W-1:0] sat;

  logic                     out_vld_r, out_vld_nxt;
  logic signed [DATA_W-1:0] out_smp_r, out_smp_nxt;
  logic                     out_last_r, out_last_nxt;
  logic                     pend_vld_r, pend_vld_nxt;
  logic signed [DATA_W-1:0] pend_smp_r, pend_smp_nxt;
  logic                     pend_last_r, pend_last_nxt;
  logic                     take;

  // round half up, then clamp
  always_comb begin
    rnd = RND_W'(done.sum) + RND_W'(1 << (DATA_W - 2));
    q   = Q_W'(rnd >>> (DATA_W - 1));
    if (q > Q_MAX)      sat = DATA_W'(Q_MAX);
    else if (q < Q_MIN) sat = DATA_W'(Q_MIN);
    else                sat = DATA_W'(q);
  end

  assign take = out_vld_r & out_tready;

  always_comb begin
    out_vld_nxt   = out_vld_r;
    out_smp_nxt   = out_smp_r;
    out_last_nxt  = out_last_r;
    pend_vld_nxt  = pend_vld_r;
    pend_smp_nxt  = pend_smp_r;
    pend_last_nxt = pend_last_r;
    if (!out_vld_r || take) begin
      if (pend_vld_r) begin
        out_vld_nxt   = 1'b1;
        out_smp_nxt   = pend_smp_r;
        out_last_nxt  = pend_last_r;
        pend_vld_nxt  = done.vld;
        pend_smp_nxt  = sat;
        pend_last_nxt = done.last;
      end else begin
        out_vld_nxt  = done.vld;
        out_smp_nxt  = sat;
        out_last_nxt = done.last;
      end
    end else if (done.vld) begin
      pend_vld_nxt  = 1'b1;
      pend_smp_nxt  = sat;
      pend_last_nxt = done.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      pend_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      pend_vld_r <= pend_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_smp_r   <= out_smp_nxt;
    out_last_r  <= out_last_nxt;
    pend_smp_r  <= pend_smp_nxt;
    pend_last_r <= pend_last_nxt;
  end

  assign pend_full  = pend_vld_r;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = OUT_TDATA_W'(out_smp_r);
  assign out_tlast  = out_last_r;

endmodule

/* sv/streaming_fir_convolver.sv */
// Top level of the streaming FIR convolver: tap cell row, frame/warm-up control, output stage.
//
//  channel   dir  beat fields
//  in_*      in   tdata: coef_index[5:0], value[21:6]; tuser: kind
//  out_*     out  tdata: out_sample[15:0]; tlast: frame_end
//  cfg_*     in   addr 0 = tap_count, addr 1 = frame_len; one write per cycle
//
// Flow: a coefficient load or a warm-up sample leaves the input ready for the next
// item. A sample that yields a result holds the input until its sum leaves the row:
// the partial sum walks the cell row one cell per cycle, then gets rounded.
// Reset: sync active low, clears coefficients, history, counters and valids.
// Stalls: the output register plus one holding slot let the next item in while
// a result waits; input stalls only while a sum is in flight or both slots are full.
module streaming_fir_convolver (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input stream
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [sfc_pkg::IN_TDATA_W-1:0]       in_tdata,   // coef_index, value, zero fill
  input  logic                                 in_tuser,   // kind
  // result stream
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [sfc_pkg::OUT_TDATA_W-1:0]      out_tdata,  // out_sample
  output logic                                 out_tlast,  // frame_end
  // configuration
  input  logic                                 cfg_we,
  input  logic [sfc_pkg::CFG_ADDR_W-1:0]       cfg_addr,
  input  logic [sfc_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
  import sfc_pkg::*;

  // input fields
  logic [IDX_W-1:0]         in_coef_index;
  logic signed [DATA_W-1:0] in_value;
  logic                     in_kind;
  assign in_coef_index = in_tdata[IDX_W-1:0];
  assign in_value      = in_tdata[IDX_W +: DATA_W];
  assign in_kind       = in_tuser;

  // config registers
  logic [CFG_TAPS_W-1:0]  tap_count_r, tap_count_nxt;
  logic [CFG_FRAME_W-1:0] frame_len_r, frame_len_nxt;

  // stream control
  logic [FPOS_W-1:0] frame_pos_r, frame_pos_nxt;
  logic [SEEN_W-1:0] seen_r, seen_nxt;
  logic              start_r, start_nxt;    // history shifted, products settling
  logic              launch_r, launch_nxt;  // sum enters cell 0
  logic              last_r, last_nxt;      // frame_end for the sum in flight

  logic [TCNT_W-1:0] taps_eff;
  logic [TCNT_W-1:0] half;
  logic [FLEN_W-1:0] flen_eff;
  logic              accept, smp_acc, coef_acc;
  logic              last, emit, wave_busy, pend_full;

  // tap row
  logic signed [DATA_W-1:0] hist [MAX_TAPS];
  sfc_wave_t                wave [MAX_TAPS+1];
  logic [MAX_TAPS-1:0]      row_vld;
  logic [MAX_TAPS-1:0]      tap_en;
  logic [MAX_TAPS-1:0]      coef_we;
  sfc_done_t                done;

  // out-of-range taps clamp to MAX_TAPS; frame length 0 acts as 1, above MAX_FRAME clamps
  always_comb begin
    if (32'(tap_count_r) > 32'(MAX_TAPS)) taps_eff = TCNT_W'(MAX_TAPS);
    else                                  taps_eff = TCNT_W'(tap_count_r);
    half = taps_eff >> 1;
    if (frame_len_r == '0)                          flen_eff = FLEN_W'(1);
    else if (32'(frame_len_r) > 32'(MAX_FRAME))     flen_eff = FLEN_W'(MAX_FRAME);
    else                                            flen_eff = FLEN_W'(frame_len_r);
  end

  assign wave_busy = start_r | launch_r | (|row_vld);
  assign in_tready = ~wave_busy & ~pend_full;
  assign accept    = in_tvalid & in_tready;
  assign smp_acc   = accept & (in_kind == KIND_SAMPLE);
  assign coef_acc  = accept & (in_kind == KIND_COEF);

  assign last = (FLEN_W'(frame_pos_r) + FLEN_W'(1)) >= flen_eff;
  assign emit = TCNT_W'(seen_r) >= half;

  always_comb begin
    tap_count_nxt = tap_count_r;
    frame_len_nxt = frame_len_r;
    if (cfg_we) begin
      case (cfg_addr)
        CFG_TAP_COUNT: tap_count_nxt = CFG_TAPS_W'(cfg_wdata);
        CFG_FRAME_LEN: frame_len_nxt = CFG_FRAME_W'(cfg_wdata);
        default: ;
      endcase
    end
  end

  always_comb begin
    frame_pos_nxt = frame_pos_r;
    seen_nxt      = seen_r;
    last_nxt      = last_r;
    start_nxt     = 1'b0;
    launch_nxt    = start_r;
    if (smp_acc) begin
      frame_pos_nxt = last ? '0 : frame_pos_r + 1'b1;
      if (emit) begin
        start_nxt = 1'b1;
        last_nxt  = last;
      end else begin
        seen_nxt = seen_r + 1'b1;  // warm-up: no result
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_count_r <= CFG_TAPS_W'(64);
      frame_len_r <= CFG_FRAME_W'(256);
      frame_pos_r <= '0;
      seen_r      <= '0;
      start_r     <= 1'b0;
      launch_r    <= 1'b0;
      last_r      <= 1'b0;
    end else begin
      tap_count_r <= tap_count_nxt;
      frame_len_r <= frame_len_nxt;
      frame_pos_r <= frame_pos_nxt;
      seen_r      <= seen_nxt;
      start_r     <= start_nxt;
      launch_r    <= launch_nxt;
      last_r      <= last_nxt;
    end
  end

  // sum enters the row after the shift, once products are registered: start_r, then launch_r
  assign wave[0].vld = launch_r;
  assign wave[0].sum = '0;

  for (genvar k = 0; k < MAX_TAPS; k++) begin : g_tap
    assign tap_en[k]  = TCNT_W'(k) < taps_eff;
    assign coef_we[k] = coef_acc & (32'(in_coef_index) == k);
    assign row_vld[k] = wave[k+1].vld;

    if (k == 0) begin : g_head
      sfc_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (smp_acc),
        .x_in     (in_value),
        .x_out    (hist[k]),
        .coef_we  (coef_we[k]),
        .coef_in  (in_value),
        .tap_en   (tap_en[k]),
        .wave_in  (wave[k]),
        .wave_out (wave[k+1])
      );
    end else begin : g_body
      sfc_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (smp_acc),
        .x_in     (hist[k-1]),
        .x_out    (hist[k]),
        .coef_we  (coef_we[k]),
        .coef_in  (in_value),
        .tap_en   (tap_en[k]),
        .wave_in  (wave[k]),
        .wave_out (wave[k+1])
      );
    end
  end

  assign done.vld  = wave[MAX_TAPS].vld;
  assign done.sum  = wave[MAX_TAPS].sum;
  assign done.last = last_r;

  sfc_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .done       (done),
    .pend_full  (pend_full),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

/* tb/streaming_fir_convolver_tb.sv */
// Self-checking testbench for streaming_fir_convolver: directed and random beats.
`timescale 1ns / 100ps

module streaming_fir_convolver_tb;
  import sfc_pkg::*;

  // Cycles to wait after the last result before the block counts as idle.
  // A sample that produces no result can still be in flight, and a result
  // sample occupies the block until its sum leaves the cell row.
  localparam int SETTLE_CYCLES = MAX_TAPS + 16;
  // Long receiver hold-off. Long enough to fill both output slots and stall input.
  localparam int HOLD_CYCLES   = 600;

  // One input beat as the sender sees it.
  typedef struct {
    logic                    kind;
    logic [IDX_W-1:0]        coef_index;
    logic signed [DATA_W-1:0] value;
  } stim_item_t;

  // One filtered output beat.
  typedef struct {
    logic signed [DATA_W-1:0] out_value;
    logic                     frame_end;
  } fir_result_t;

  logic clk;
  logic rst_n;

  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;   // coef_index[5:0], value[21:6], zero fill
  logic                   in_tuser   = 1'b0; // kind
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;         // out_sample[15:0]
  logic                   out_tlast;         // frame_end
  logic                   cfg_we;
  logic [CFG_ADDR_W-1:0]  cfg_addr;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  streaming_fir_convolver i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // --------------------------------------------------------------------------
  // Shared testbench state
  // --------------------------------------------------------------------------
  stim_item_t  stim_q[$];        // beats waiting for the driver
  fir_result_t filter_out_q[$];  // predicted output beats, oldest first

  bit in_gaps_on    = 1'b0;      // sender inserts random gaps
  bit out_stalls_on = 1'b0;      // receiver drops tready at random
  bit hold_request  = 1'b0;      // kicks off the one long receiver hold-off
  logic rx_hold     = 1'b0;

  int mismatch_count = 0;
  int samples_in     = 0;
  int coef_loads     = 0;
  int beats_out      = 0;
  int flags_out      = 0;
  int settings_used  = 0;

  // Predictor state: coefficient bank, sample delay line, frame and warm-up
  // counters, and its own copy of the two registers.
  logic signed [DATA_W-1:0] coef_bank   [MAX_TAPS];
  logic signed [DATA_W-1:0] tap_history [MAX_TAPS];
  int unsigned              frame_pos;
  int unsigned              warm_count;
  logic [CFG_TAPS_W-1:0]    taps_reg;
  logic [CFG_FRAME_W-1:0]   flen_reg;

  // --------------------------------------------------------------------------
  // Clock and watchdog
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: reports a failure if the run hangs. The worst correct run, roughly 1400
  // beats with sender gaps and receiver stalls, ends well before it fires.
  initial begin
    #8_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Helpers
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap(input bit enabled);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Q1.15 value: rails, small values (to stay out of saturation), or full random.
  function automatic logic signed [DATA_W-1:0] rand_q15();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'sh7FFF;
    if (r == 1) return 16'sh8000;
    if (r < 5) return DATA_W'($urandom_range(0, 4095) - 2048);
    return DATA_W'($urandom());
  endfunction

  function automatic void push_item(input logic kind, input logic [IDX_W-1:0] idx,
                                    input logic signed [DATA_W-1:0] value);
    stim_item_t it;
    it.kind       = kind;
    it.coef_index = idx;
    it.value      = value;
    stim_q.push_back(it);
  endfunction

  function automatic void reset_filter_model();
    foreach (coef_bank[i]) begin
      coef_bank[i]   = '0;
      tap_history[i] = '0;
    end
    frame_pos  = 0;
    warm_count = 0;
    taps_reg   = CFG_TAPS_W'(64);
    flen_reg   = CFG_FRAME_W'(256);
    filter_out_q.delete();
  endfunction

  // Direct-form FIR step for one accepted input beat; queues the output beat if any.
  function automatic void filter_step(input logic kind, input logic [IDX_W-1:0] idx,
                                      input logic signed [DATA_W-1:0] value);
    int unsigned taps;
    int unsigned half;
    int unsigned flen;
    logic        closes_frame;
    longint      acc;
    longint      q;
    fir_result_t res;
    if (kind == KIND_COEF) begin
      // takes effect from the next sample
      coef_bank[idx] = value;
      coef_loads++;
      return;
    end
    samples_in++;
    taps = (taps_reg > MAX_TAPS) ? MAX_TAPS : taps_reg;
    half = taps / 2;
    if (flen_reg == 0) flen = 1;
    else flen = (flen_reg > MAX_FRAME) ? MAX_FRAME : flen_reg;

    for (int k = MAX_TAPS - 1; k > 0; k--) tap_history[k] = tap_history[k-1];
    tap_history[0] = value;

    // frame position counts warm-up samples too
    closes_frame = (frame_pos + 1 >= flen);
    frame_pos    = closes_frame ? 0 : frame_pos + 1;

    // first taps/2 samples only fill the delay line
    if (warm_count < half) begin
      warm_count++;
      return;
    end

    acc = 0;
    for (int k = 0; k < taps; k++)
      acc += longint'(coef_bank[k]) * longint'(tap_history[k]);
    // Q2.30 -> Q1.15, round half up, then clamp to 16 bits
    q = (acc + 16384) >>> 15;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    res.out_value = q[DATA_W-1:0];
    res.frame_end = closes_frame;
    filter_out_q.push_back(res);
  endfunction

  // --------------------------------------------------------------------------
  // Driver: presents queued beats, holds them until accepted, then maybe gaps.
  // --------------------------------------------------------------------------
  int gap_left = 0;

  always @(posedge clk) begin : drive_beats
    stim_item_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      gap_left  <= 0;
    end else if (!(in_tvalid && !in_tready)) begin
      // nothing on the bus, or the current beat went through at this edge
      if (gap_left > 0) begin
        gap_left  <= gap_left - 1;
        in_tvalid <= 1'b0;
      end else if (stim_q.size() != 0) begin
        nxt = stim_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= IN_TDATA_W'({nxt.value, nxt.coef_index});
        in_tuser  <= nxt.kind;
        gap_left  <= pick_gap(in_gaps_on);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random stalls, plus the long hold-off when rx_hold is up.
  // --------------------------------------------------------------------------
  int stall_left = 0;

  always @(posedge clk) begin : accept_beats
    int g;
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left <= 0;
    end else if (rx_hold) begin
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else begin
      g = 0;
      if ((out_tvalid && out_tready) || $urandom_range(0, 19) == 0) g = pick_gap(out_stalls_on);
      if (g > 0) begin
        out_tready <= 1'b0;
        stall_left <= g - 1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // One long hold-off, counted here so it runs regardless of what the sender does.
  initial begin
    wait (hold_request);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor: tracks register writes and accepted input beats.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      reset_filter_model();
    end else begin
      if (cfg_we) begin
        if (cfg_addr == CFG_TAP_COUNT) taps_reg = cfg_wdata[CFG_TAPS_W-1:0];
        else if (cfg_addr == CFG_FRAME_LEN) flen_reg = cfg_wdata[CFG_FRAME_W-1:0];
      end
      if (in_tvalid && in_tready)
        filter_step(in_tuser, in_tdata[IDX_W-1:0], in_tdata[IDX_W +: DATA_W]);
    end
  end

  // --------------------------------------------------------------------------
  // Checker: every output beat against the oldest prediction.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_beats
    fir_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      beats_out++;
      if (out_tlast) flags_out++;
      if (filter_out_q.size() == 0) begin
        report_mismatch($sformatf("output beat 0x%04h/%0b with nothing predicted",
                                  out_tdata, out_tlast));
      end else begin
        want = filter_out_q.pop_front();
        if (out_tdata[DATA_W-1:0] !== want.out_value)
          report_mismatch($sformatf("beat %0d out_sample %0d, predicted %0d", beats_out,
                                    $signed(out_tdata[DATA_W-1:0]), want.out_value));
        if (out_tlast !== want.frame_end)
          report_mismatch($sformatf("beat %0d frame_end %0b, predicted %0b", beats_out,
                                    out_tlast, want.frame_end));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus sequencing
  // --------------------------------------------------------------------------
  // Block is idle: nothing queued, nothing on the bus, nothing predicted, and
  // then a SETTLE_CYCLES wait for a trailing no-result sample. Checked at
  // negedge so the posedge updates have landed.
  task automatic settle();
    @(negedge clk);
    while (stim_q.size() != 0 || in_tvalid || filter_out_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input int unsigned data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= CFG_DATA_W'(data);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_filter(input int unsigned taps, input int unsigned flen);
    write_reg(CFG_TAP_COUNT, taps);
    write_reg(CFG_FRAME_LEN, flen);
    settings_used++;
  endtask

  // Random beats: coef_pct percent coefficient loads, the rest samples.
  // Samples carry a random coef_index too; the block must ignore it.
  task automatic random_phase(input int unsigned taps, input int unsigned flen,
                              input int n, input int coef_pct,
                              input bit gaps, input bit stalls);
    set_filter(taps, flen);
    in_gaps_on    = gaps;
    out_stalls_on = stalls;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < coef_pct)
        push_item(KIND_COEF, IDX_W'($urandom()), rand_q15());
      else
        push_item(KIND_SAMPLE, IDX_W'($urandom()), rand_q15());
    end
    settle();
  endtask

  initial begin
    cfg_we    = 1'b0;
    cfg_addr  = CFG_TAP_COUNT;
    cfg_wdata = '0;
    rst_n     = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: two taps, frame of three, no idling.
    set_filter(2, 3);
    push_item(KIND_COEF,   6'd0,  16'sd1);
    push_item(KIND_COEF,   6'd1,  16'sd0);
    push_item(KIND_SAMPLE, 6'd0,  16'sd0);        // warm-up, no beat out
    push_item(KIND_SAMPLE, 6'd63, 16'sd16384);    // exactly half an LSB rounds up
    push_item(KIND_SAMPLE, 6'd0,  -16'sd16384);   // negative half rounds up to zero
    push_item(KIND_SAMPLE, 6'd0,  -16'sd16385);
    push_item(KIND_COEF,   6'd0,  16'sh8000);     // new value used by the next sample
    push_item(KIND_COEF,   6'd1,  16'sh8000);
    push_item(KIND_SAMPLE, 6'd0,  16'sh8000);     // -1 * -1 overflows, clamps high
    push_item(KIND_SAMPLE, 6'd0,  16'sh8000);
    push_item(KIND_COEF,   6'd0,  16'sh7FFF);
    push_item(KIND_COEF,   6'd1,  16'sh7FFF);
    push_item(KIND_SAMPLE, 6'd0,  16'sh7FFF);
    push_item(KIND_SAMPLE, 6'd0,  16'sh7FFF);     // clamps high
    push_item(KIND_COEF,   6'd1,  16'sh8000);
    push_item(KIND_SAMPLE, 6'd0,  16'sh8000);     // clamps low
    push_item(KIND_SAMPLE, 6'd0,  16'sh8000);
    push_item(KIND_COEF,   6'd63, -16'sd1);       // top of the bank
    push_item(KIND_COEF,   6'd42, 16'sh5555);
    push_item(KIND_COEF,   6'd21, 16'shAAAA);
    push_item(KIND_SAMPLE, 6'd42, 16'sh5555);
    push_item(KIND_SAMPLE, 6'd21, 16'shAAAA);
    settle();

    // Taps grow to 64: warm-up resumes against the new half, and with a frame
    // of three several frames close with no flagged beat.
    random_phase(64, 3, 150, 20, 1'b1, 1'b1);

    // Out-of-range registers saturate. Receiver holds off long while the
    // sender keeps offering, so the block fills up and stalls its input.
    hold_request = 1'b1;
    random_phase(127, 8191, 150, 10, 1'b0, 1'b0);

    // No taps: every beat is zero, no warm-up; frame length 0 flags every beat.
    random_phase(0, 0, 80, 20, 1'b1, 1'b1);

    // Single tap, largest legal frame.
    random_phase(1, 4096, 150, 15, 1'b1, 1'b0);

    // Odd tap count and frame; split in two so the sender waits out all results.
    random_phase(17, 37, 130, 15, 1'b0, 1'b1);
    random_phase(17, 37, 130, 15, 1'b1, 1'b1);

    // Frame shrinks under a running position: the next sample closes the frame.
    random_phase(64, 1, 100, 10, 1'b1, 1'b1);

    // Assorted settings.
    for (int p = 0; p < 6; p++)
      random_phase($urandom_range(1, MAX_TAPS), $urandom_range(1, 200), 75, 15, 1'b1, 1'b1);

    settle();
    if (filter_out_q.size() != 0)
      report_mismatch($sformatf("%0d predicted beats never came out", filter_out_q.size()));

    $display("Covered %0d samples and %0d coefficient loads over %0d register settings;",
             samples_in, coef_loads, settings_used);
    $display("checked %0d output beats, %0d of them frame ends.", beats_out, flags_out);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* streaming_fir_convolver.f */
sv/sfc_pkg.sv
sv/sfc_cell.sv
sv/sfc_out_stage.sv
sv/streaming_fir_convolver.sv
tb/streaming_fir_convolver_tb.sv
